/* design/pso_particle_update_assert.svh */
`ifndef PSO_PARTICLE_UPDATE_ASSERT_SVH
`define PSO_PARTICLE_UPDATE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PSO_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition that must hold on every clock edge outside reset
`define PSO_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

/* design/pso_upd_pkg.sv */
package pso_upd_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned LIMIT_W = 31;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned DRAW_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned PIPE_DEPTH = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INERTIA_WEIGHT = 2'd0,
      CSR_COGNITIVE_GAIN = 2'd1,
      CSR_SOCIAL_GAIN    = 2'd2
   } csr_index_type;

   localparam logic [COEF_W-1:0] INERTIA_WEIGHT_RESET = 16'd2986;
   localparam logic [COEF_W-1:0] COGNITIVE_GAIN_RESET = 16'd6121;
   localparam logic [COEF_W-1:0] SOCIAL_GAIN_RESET    = 16'd6121;

endpackage

/* design/pso_particle_update.sv */
// Particle swarm update for one dimension of one particle per beat.
// Request channel: a beat is taken on a rising edge with start high and
// busy low; busy is always low, so a new beat may be issued every cycle.
// Response channel: rsp_strobe marks each result for exactly one cycle;
// the receiver cannot stall, and none is needed since nothing backs up.
// Throughput: one beat per cycle, set by the seven-stage pipeline
// (gain and inertia multiply, attraction multiply, rounding, sum and
// saturation, velocity clamp, position add, position clamp).
// Configuration: csr_write_enable writes csr_write_data[15:0] into the
// register at csr_index (0 inertia, 1 cognitive, 2 social; 3 is ignored).
// Write only while no beat is in flight.
// Reset (synchronous, active high) restores the default coefficients and
// drops every beat in flight; no result strobes for a dropped beat.
module pso_particle_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_current_position,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_current_velocity,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_personal_best,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_swarm_best,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_lower_bound,
   input  logic signed [pso_upd_pkg::VALUE_W-1:0] req_upper_bound,
   input  logic        [pso_upd_pkg::LIMIT_W-1:0] req_velocity_limit,
   input  logic        [pso_upd_pkg::DRAW_W-1:0]  req_personal_draw,
   input  logic        [pso_upd_pkg::DRAW_W-1:0]  req_swarm_draw,
   output logic                                rsp_strobe,
   output logic signed [pso_upd_pkg::VALUE_W-1:0] rsp_next_velocity,
   output logic signed [pso_upd_pkg::VALUE_W-1:0] rsp_next_position,
   output logic                                rsp_velocity_clamped,
   output logic                                rsp_position_clamped,
   input  logic                                csr_write_enable,
   input  logic        [pso_upd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [pso_upd_pkg::COEF_W-1:0]  csr_write_data
);
   import pso_upd_pkg::*;

   localparam logic signed [39:0] SUM_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [39:0] SUM_MIN = 40'shFF_8000_0000;

   logic [COEF_W-1:0] inertia_ff, cognitive_ff, social_ff;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   // payload carried down the pipe
   logic signed [VALUE_W-1:0] pos_ff [1:6];
   logic signed [VALUE_W-1:0] lo_ff  [1:6];
   logic signed [VALUE_W-1:0] hi_ff  [1:6];
   logic        [LIMIT_W-1:0] lim_ff [1:4];

   // stage 1
   logic signed [48:0] inertia_prod_ff, inertia_prod_in;
   logic [COEF_W-1:0]  coef_p_ff, coef_p_in, coef_g_ff, coef_g_in;
   logic [31:0]        coef_p_full, coef_g_full;
   logic signed [32:0] diff_p_ff, diff_p_in, diff_g_ff, diff_g_in;
   // stage 2
   logic signed [48:0] inertia_rnd;
   logic signed [37:0] inertia_term_ff, inertia_term_in;
   logic signed [49:0] attr_p_prod_ff, attr_p_prod_in, attr_g_prod_ff, attr_g_prod_in;
   // stage 3
   logic signed [49:0] attr_p_rnd, attr_g_rnd;
   logic signed [37:0] inertia_term3_ff, term_p_ff, term_p_in, term_g_ff, term_g_in;
   // stage 4
   logic signed [39:0] sum_full;
   logic signed [VALUE_W-1:0] vel_sat_ff, vel_sat_in;
   // stage 5
   logic signed [32:0] vel_wide, lim_wide;
   logic signed [VALUE_W-1:0] vel_ff, vel_in, vel6_ff, vel7_ff;
   logic vclip_ff, vclip_in, vclip6_ff, vclip7_ff;
   // stage 6
   logic signed [32:0] npos_ff, npos_in;
   // stage 7
   logic signed [VALUE_W-1:0] pos_out_ff, pos_out_in;
   logic pclip_ff, pclip_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_ff   <= INERTIA_WEIGHT_RESET;
         cognitive_ff <= COGNITIVE_GAIN_RESET;
         social_ff    <= SOCIAL_GAIN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_INERTIA_WEIGHT: inertia_ff   <= csr_write_data;
            CSR_COGNITIVE_GAIN: cognitive_ff <= csr_write_data;
            CSR_SOCIAL_GAIN:    social_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

      inertia_prod_in = 49'($signed({1'b0, inertia_ff})) * 49'(req_current_velocity);
      coef_p_full = 32'(cognitive_ff) * 32'(req_personal_draw) + 32'h0000_8000;
      coef_g_full = 32'(social_ff) * 32'(req_swarm_draw) + 32'h0000_8000;
      coef_p_in = coef_p_full[31:16];
      coef_g_in = coef_g_full[31:16];
      diff_p_in = 33'(req_personal_best) - 33'(req_current_position);
      diff_g_in = 33'(req_swarm_best) - 33'(req_current_position);

      inertia_rnd = inertia_prod_ff + 49'sd2048;
      inertia_term_in = 38'(inertia_rnd >>> 12);
      attr_p_prod_in = 50'($signed({1'b0, coef_p_ff})) * 50'(diff_p_ff);
      attr_g_prod_in = 50'($signed({1'b0, coef_g_ff})) * 50'(diff_g_ff);

      attr_p_rnd = attr_p_prod_ff + 50'sd2048;
      attr_g_rnd = attr_g_prod_ff + 50'sd2048;
      term_p_in = 38'(attr_p_rnd >>> 12);
      term_g_in = 38'(attr_g_rnd >>> 12);

      sum_full = 40'(inertia_term3_ff) + 40'(term_p_ff) + 40'(term_g_ff);
      if (sum_full > SUM_MAX) begin
         vel_sat_in = 32'sh7FFF_FFFF;
      end else if (sum_full < SUM_MIN) begin
         vel_sat_in = 32'sh8000_0000;
      end else begin
         vel_sat_in = sum_full[31:0];
      end

      vel_wide = 33'(vel_sat_ff);
      lim_wide = $signed({2'b00, lim_ff[4]});
      vclip_in = 1'b1;
      if (vel_wide > lim_wide) begin
         vel_in = lim_wide[31:0];
      end else if (vel_wide < -lim_wide) begin
         vel_in = 32'(-lim_wide);
      end else begin
         vel_in = vel_sat_ff;
         vclip_in = 1'b0;
      end

      npos_in = 33'(pos_ff[5]) + 33'(vel_ff);

      pclip_in = 1'b1;
      if (npos_ff > 33'(hi_ff[6])) begin
         pos_out_in = hi_ff[6];
      end else if (npos_ff < 33'(lo_ff[6])) begin
         pos_out_in = lo_ff[6];
      end else begin
         pos_out_in = npos_ff[31:0];
         pclip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff[1] <= req_current_position;
      lo_ff[1]  <= req_lower_bound;
      hi_ff[1]  <= req_upper_bound;
      lim_ff[1] <= req_velocity_limit;
      for (int i = 2; i <= 6; i++) begin
         pos_ff[i] <= pos_ff[i-1];
         lo_ff[i]  <= lo_ff[i-1];
         hi_ff[i]  <= hi_ff[i-1];
      end
      for (int i = 2; i <= 4; i++) begin
         lim_ff[i] <= lim_ff[i-1];
      end

      inertia_prod_ff  <= inertia_prod_in;
      coef_p_ff        <= coef_p_in;
      coef_g_ff        <= coef_g_in;
      diff_p_ff        <= diff_p_in;
      diff_g_ff        <= diff_g_in;

      inertia_term_ff  <= inertia_term_in;
      attr_p_prod_ff   <= attr_p_prod_in;
      attr_g_prod_ff   <= attr_g_prod_in;

      inertia_term3_ff <= inertia_term_ff;
      term_p_ff        <= term_p_in;
      term_g_ff        <= term_g_in;

      vel_sat_ff       <= vel_sat_in;

      vel_ff           <= vel_in;
      vclip_ff         <= vclip_in;

      npos_ff          <= npos_in;
      vel6_ff          <= vel_ff;
      vclip6_ff        <= vclip_ff;

      pos_out_ff       <= pos_out_in;
      pclip_ff         <= pclip_in;
      vel7_ff          <= vel6_ff;
      vclip7_ff        <= vclip6_ff;
   end

   assign rsp_strobe           = valid_ff[PIPE_DEPTH-1];
   assign rsp_next_velocity    = vel7_ff;
   assign rsp_next_position    = pos_out_ff;
   assign rsp_velocity_clamped = vclip7_ff;
   assign rsp_position_clamped = pclip_ff;

endmodule

/* design/pso_upd_checker.sv */
`include "pso_particle_update_assert.svh"

module pso_upd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [pso_upd_pkg::VALUE_W-1:0] req_lower_bound,
   input logic signed [pso_upd_pkg::VALUE_W-1:0] req_upper_bound,
   input logic        [pso_upd_pkg::LIMIT_W-1:0] req_velocity_limit,
   input logic                                rsp_strobe,
   input logic signed [pso_upd_pkg::VALUE_W-1:0] rsp_next_velocity,
   input logic signed [pso_upd_pkg::VALUE_W-1:0] rsp_next_position,
   input logic                                rsp_velocity_clamped,
   input logic                                rsp_position_clamped
);
   import pso_upd_pkg::*;

   `PSO_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy asserted")

   `PSO_ASSERT_IMPLY(a_strobe_has_beat, clock, reset, rsp_strobe,
      $past(start && !busy, PIPE_DEPTH), "result strobe without accepted beat")

   `PSO_ASSERT_IMPLY(a_vel_at_limit, clock, reset, rsp_strobe && rsp_velocity_clamped,
      (33'(rsp_next_velocity) ==
       $signed({2'b00, $past(req_velocity_limit, PIPE_DEPTH)})) ||
      (33'(rsp_next_velocity) ==
       -$signed({2'b00, $past(req_velocity_limit, PIPE_DEPTH)})),
      "clamped velocity not at limit")

   `PSO_ASSERT_IMPLY(a_pos_at_bound, clock, reset, rsp_strobe && rsp_position_clamped,
      (rsp_next_position == $past(req_upper_bound, PIPE_DEPTH)) ||
      (rsp_next_position == $past(req_lower_bound, PIPE_DEPTH)),
      "clamped position not at a bound")

endmodule

bind pso_particle_update pso_upd_checker u_pso_upd_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_lower_bound      (req_lower_bound),
   .req_upper_bound      (req_upper_bound),
   .req_velocity_limit   (req_velocity_limit),
   .rsp_strobe           (rsp_strobe),
   .rsp_next_velocity    (rsp_next_velocity),
   .rsp_next_position    (rsp_next_position),
   .rsp_velocity_clamped (rsp_velocity_clamped),
   .rsp_position_clamped (rsp_position_clamped)
);
